### rtl/ppfc_pkg.sv
// Package for the palette pixel format converter.
// Holds the format and opcode codes, the fixed-point gray weights and the byte burst type.
// No dependencies.
package ppfc_pkg;

	// Destination byte address width
	localparam int ADDR_W = 22;

	// Palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_W       = 24;

	// Pitch saturation limit
	localparam logic [11:0] PITCH_LIMIT = 12'd2048;

	// Fixed-point luma weights (0.21, 0.72, 0.07 scaled by 256)
	localparam logic [15:0] GRAY_R = 16'd54;
	localparam logic [15:0] GRAY_G = 16'd184;
	localparam logic [15:0] GRAY_B = 16'd18;

	// Alpha byte for the four-byte layouts
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Configuration reset values
	localparam logic [10:0] RST_WIDTH  = 11'd320;
	localparam logic [10:0] RST_HEIGHT = 11'd240;
	localparam logic [11:0] RST_PITCH  = 12'd320;

	typedef enum logic [3:0] {
		FMT_PLANAR_RGB = 4'd0,
		FMT_RGB24      = 4'd1,
		FMT_RGBA32     = 4'd2,
		FMT_ARGB32     = 4'd3,
		FMT_PLANAR_BGR = 4'd4,
		FMT_BGR24      = 4'd5,
		FMT_BGRA32     = 4'd6,
		FMT_ABGR32     = 4'd7,
		FMT_GRAY       = 4'd8,
		FMT_INDEX      = 4'd9
	} fmt_t;

	typedef enum logic [1:0] {
		CFG_FORMAT = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2,
		CFG_PITCH  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	// Up to four addressed bytes of one pixel; last is the index of the final byte
	typedef struct packed {
		logic [3:0][ADDR_W-1:0] addr;
		logic [3:0][7:0]        value;
		logic [1:0]             last;
	} burst_t;

endpackage

### rtl/ppfc_item_if.sv
// Input item channel of the palette pixel format converter.
// Carries palette writes and source pixels; no dependencies.
interface ppfc_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] entry_index;
	logic [7:0] entry_red;
	logic [7:0] entry_green;
	logic [7:0] entry_blue;
	logic [7:0] pixel_code;

	modport source (
		output valid, op, entry_index, entry_red, entry_green, entry_blue, pixel_code,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_red, entry_green, entry_blue, pixel_code,
		output ready
	);
endinterface

### rtl/ppfc_result_if.sv
// Result byte channel of the palette pixel format converter.
// Depends on ppfc_pkg for the address width.
interface ppfc_result_if
	import ppfc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] out_address;
	logic [7:0]        out_value;
	logic              last_of_pixel;

	modport source (
		output valid, out_address, out_value, last_of_pixel,
		input  ready
	);
	modport sink (
		input  valid, out_address, out_value, last_of_pixel,
		output ready
	);
endinterface

### rtl/ppfc_cfg_if.sv
// Configuration write channel of the palette pixel format converter.
// Register index and write data; no dependencies.
interface ppfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ppfc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppfc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ppfc_emit.sv
// Byte sequencer: holds one pixel's burst and sends its bytes one per transaction.
// Depends on ppfc_pkg (burst_t) and ppfc_result_if.
module ppfc_emit
	import ppfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	output logic          load_ready,
	input  burst_t        burst,
	ppfc_result_if.source dst
);

	logic       busy_q;
	logic [1:0] k_q;
	burst_t     burst_q;
	logic       final_taken;

	assign final_taken = busy_q && dst.ready && (k_q == burst_q.last);
	assign load_ready  = !busy_q || final_taken;

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= 2'd0;
		end else if (load_valid && load_ready) begin
			busy_q <= 1'b1;
			k_q    <= 2'd0;
		end else if (final_taken) begin
			busy_q <= 1'b0;
		end else if (busy_q && dst.ready) begin
			k_q <= k_q + 2'd1;
		end
	end

	// Hold the burst payload
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			burst_q <= burst;
		end
	end

	// Drive the current byte
	assign dst.valid         = busy_q;
	assign dst.out_address   = burst_q.addr[k_q];
	assign dst.out_value     = burst_q.value[k_q];
	assign dst.last_of_pixel = (k_q == burst_q.last);

endmodule

### rtl/palette_pixel_format_converter.sv
// Top level of the palette pixel format converter.
// Depends on ppfc_pkg, the three channel interfaces, ppfc_ram and ppfc_emit.
//
// Palette-indexed pixels in, addressed destination bytes out. Op-0 items write
// the 256 x 24 palette RAM. Padding columns (and pixels of an unknown format)
// vanish, and kept pixels look up the palette (registered RAM read) and
// produce 1 (gray, index), 3 (RGB24, BGR24, planar) or 4 (32-bit layouts)
// bytes, sent one byte per cycle on the result port while it is ready. The
// single-byte result port sets the sustained rate, lower for wider layouts.
// Input is accepted while a burst drains, with one pixel held in the lookup
// stage, so the first byte of a pixel follows the last byte of the previous
// one with no gap; an accepted pixel passes the lookup and burst registers
// before its first byte. The palette has no reset; configuration registers apply at once.
module palette_pixel_format_converter
	import ppfc_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	ppfc_item_if.sink   src,
	ppfc_result_if.source dst,
	ppfc_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int PL_W  = CNT_W + 1;

	// Configuration registers
	fmt_t        fmt_q;
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [11:0] pitch_q;

	// Position counters
	logic [10:0]      col_q;
	logic [CNT_W-1:0] cnt_q;

	// Derived geometry
	logic [10:0]      w_c;
	logic [10:0]      h_c;
	logic [11:0]      pitch_sat_c;
	logic [11:0]      pitch_c;
	logic [21:0]      area_c;
	logic [PL_W-1:0]  plane_c;
	logic [10:0]      col_c;
	logic [11:0]      col_inc_c;
	logic [10:0]      col_next_c;
	logic             keep_c;
	logic             known_c;
	logic [CNT_W-1:0] i_c;
	logic [PL_W-1:0]  i_inc_c;
	logic [CNT_W-1:0] i_next_c;

	// Handshake terms
	logic pix_acc;
	logic wr_acc;
	logic load_ready;

	// Lookup stage
	logic             v_s1;
	fmt_t             fmt_s1;
	logic [CNT_W-1:0] i_s1;
	logic [PL_W-1:0]  plane_s1;
	logic [7:0]       code_s1;
	logic [PAL_W-1:0] rgb_rd;

	// Burst build
	logic [7:0]        r_c;
	logic [7:0]        g_c;
	logic [7:0]        b_c;
	logic [15:0]       luma_c;
	logic [ADDR_W-1:0] base_c;
	logic [ADDR_W-1:0] pl_c;
	logic [ADDR_W-1:0] pl2_c;
	logic [ADDR_W-1:0] pos3_c;
	logic [ADDR_W-1:0] pos4_c;
	burst_t            burst_c;

	assign cfg.ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RGB24;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			pitch_q  <= RST_PITCH;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_FORMAT: fmt_q    <= fmt_t'(cfg.data[3:0]);
				CFG_WIDTH:  width_q  <= cfg.data[10:0];
				CFG_HEIGHT: height_q <= cfg.data[10:0];
				CFG_PITCH:  pitch_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamp the frame geometry
	always_comb begin
		if (width_q == 11'd0) begin
			w_c = 11'd1;
		end else if (width_q > MAX_WIDTH) begin
			w_c = 11'(MAX_WIDTH);
		end else begin
			w_c = width_q;
		end
		if (height_q == 11'd0) begin
			h_c = 11'd1;
		end else if (height_q > MAX_HEIGHT) begin
			h_c = 11'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
		pitch_sat_c = (pitch_q > PITCH_LIMIT) ? PITCH_LIMIT : pitch_q;
		pitch_c     = (pitch_sat_c < {1'b0, w_c}) ? {1'b0, w_c} : pitch_sat_c;
		area_c      = w_c * h_c;
		plane_c     = PL_W'(area_c);
	end

	// Column and pixel counter arithmetic
	always_comb begin
		col_c      = ({1'b0, col_q} < pitch_c) ? col_q : 11'd0;
		col_inc_c  = {1'b0, col_c} + 12'd1;
		col_next_c = (col_inc_c >= pitch_c) ? 11'd0 : col_inc_c[10:0];
		keep_c     = (col_c < w_c);
		known_c    = (fmt_q <= FMT_INDEX);
		i_c        = ({1'b0, cnt_q} < plane_c) ? cnt_q : '0;
		i_inc_c    = {1'b0, i_c} + PL_W'(1);
		i_next_c   = (i_inc_c >= plane_c) ? '0 : i_inc_c[CNT_W-1:0];
	end

	assign src.ready = !v_s1 || load_ready;
	assign pix_acc   = src.valid && src.ready && (src.op == OP_PIXEL);
	assign wr_acc    = src.valid && src.ready && (src.op == OP_WRITE);

	// Advance counters on each source pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			cnt_q <= '0;
		end else if (pix_acc) begin
			col_q <= col_next_c;
			if (keep_c) begin
				cnt_q <= i_next_c;
			end
		end
	end

	// Palette store
	ppfc_ram #(
		.WIDTH(PAL_W),
		.DEPTH(PAL_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (wr_acc),
		.waddr (src.entry_index),
		.wdata ({src.entry_red, src.entry_green, src.entry_blue}),
		.re    (pix_acc),
		.raddr (src.pixel_code),
		.rdata (rgb_rd)
	);

	// Lookup stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src.ready) begin
			v_s1 <= pix_acc && keep_c && known_c;
		end
	end

	// Lookup stage payload
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			fmt_s1   <= fmt_q;
			i_s1     <= i_c;
			plane_s1 <= plane_c;
			code_s1  <= src.pixel_code;
		end
	end

	// Build the byte burst from the palette color
	always_comb begin
		r_c    = rgb_rd[23:16];
		g_c    = rgb_rd[15:8];
		b_c    = rgb_rd[7:0];
		luma_c = {8'd0, r_c} * GRAY_R + {8'd0, g_c} * GRAY_G + {8'd0, b_c} * GRAY_B;
		base_c = ADDR_W'(i_s1);
		pl_c   = ADDR_W'(plane_s1);
		pl2_c  = pl_c << 1;
		pos3_c = (base_c << 1) + base_c;
		pos4_c = base_c << 2;
		burst_c       = '0;
		burst_c.value = {ALPHA_OPAQUE, b_c, g_c, r_c};
		case (fmt_s1)
			FMT_PLANAR_RGB: begin
				burst_c.addr = {ADDR_W'(0), base_c + pl2_c, base_c + pl_c, base_c};
				burst_c.last = 2'd2;
			end
			FMT_PLANAR_BGR: begin
				burst_c.addr = {ADDR_W'(0), base_c, base_c + pl_c, base_c + pl2_c};
				burst_c.last = 2'd2;
			end
			FMT_RGB24: begin
				burst_c.addr = {ADDR_W'(0), pos3_c, pos3_c + ADDR_W'(1), pos3_c + ADDR_W'(2)};
				burst_c.last = 2'd2;
			end
			FMT_BGR24: begin
				burst_c.addr = {ADDR_W'(0), pos3_c + ADDR_W'(2), pos3_c + ADDR_W'(1), pos3_c};
				burst_c.last = 2'd2;
			end
			FMT_RGBA32: begin
				burst_c.addr = {pos4_c, pos4_c + ADDR_W'(1), pos4_c + ADDR_W'(2),
					pos4_c + ADDR_W'(3)};
				burst_c.last = 2'd3;
			end
			FMT_ARGB32: begin
				burst_c.addr = {pos4_c + ADDR_W'(3), pos4_c, pos4_c + ADDR_W'(1),
					pos4_c + ADDR_W'(2)};
				burst_c.last = 2'd3;
			end
			FMT_BGRA32: begin
				burst_c.addr = {pos4_c, pos4_c + ADDR_W'(3), pos4_c + ADDR_W'(2),
					pos4_c + ADDR_W'(1)};
				burst_c.last = 2'd3;
			end
			FMT_ABGR32: begin
				burst_c.addr = {pos4_c + ADDR_W'(3), pos4_c + ADDR_W'(2),
					pos4_c + ADDR_W'(1), pos4_c};
				burst_c.last = 2'd3;
			end
			FMT_GRAY: begin
				burst_c.addr[0]  = base_c;
				burst_c.value[0] = luma_c[15:8];
				burst_c.last     = 2'd0;
			end
			FMT_INDEX: begin
				burst_c.addr[0]  = base_c;
				burst_c.value[0] = code_s1;
				burst_c.last     = 2'd0;
			end
			default: ;
		endcase
	end

	// Byte sequencer
	ppfc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s1),
		.load_ready (load_ready),
		.burst      (burst_c),
		.dst        (dst)
	);

endmodule

### rtl/ppfc_checker.sv
// Port-level checks for the palette pixel format converter, bound to the top level.
// Depends on ppfc_pkg for the address width.
module ppfc_checker
	import ppfc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              dst_valid,
	input logic              dst_ready,
	input logic [ADDR_W-1:0] dst_address,
	input logic [7:0]        dst_value,
	input logic              dst_last
);

	// Hold a stalled result byte
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("result valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> $stable(dst_address) && $stable(dst_value)
			&& $stable(dst_last))
		else $error("result payload changed while stalled");

	// A burst continues without a gap until its final byte
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_ready && !dst_last |=> dst_valid)
		else $error("burst broke before its final byte");

	// No result directly out of reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !dst_valid)
		else $error("result valid right after reset");

endmodule

bind palette_pixel_format_converter ppfc_checker u_ppfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.dst_valid   (dst.valid),
	.dst_ready   (dst.ready),
	.dst_address (dst.out_address),
	.dst_value   (dst.out_value),
	.dst_last    (dst.last_of_pixel)
);
